[design/ferp_pkg.sv]
// Package with the types, codes and constants shared by the erase range planner.
package ferp_pkg;

  localparam int SECTOR_W = 12;
  localparam int COUNT_W = 9;
  localparam int SHIFT_W = 5;
  localparam int ADDR_W = 24;
  localparam int UNIT_W = 5;
  localparam int OPCODE_W = 8;
  localparam int COUNT_LIMIT_DEF = 511;

  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd12;

  localparam logic [OPCODE_W-1:0] OP_BLOCK64 = 8'hD8;
  localparam logic [OPCODE_W-1:0] OP_BLOCK32 = 8'h52;
  localparam logic [OPCODE_W-1:0] OP_SECTOR = 8'h20;

  localparam logic [UNIT_W-1:0] UNIT64 = UNIT_W'(64 / 4);
  localparam logic [UNIT_W-1:0] UNIT32 = UNIT_W'(32 / 4);
  localparam logic [UNIT_W-1:0] UNIT1 = UNIT_W'(1);

  localparam logic [2:0] REG_SECTOR_SHIFT = 3'd0;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic count_nonzero;
    logic slot_free;
    logic step_last;
  } ctrl_status_t;

endpackage

[design/ferp_ctrl.sv]
// Controller state machine that sequences loading a request and emitting its commands.
module ferp_ctrl
  import ferp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  ctrl_status_t status,
  output ctrl_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid && status.count_nonzero) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (status.slot_free && status.step_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ST_RUN: begin
        cmd.step = status.slot_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

endmodule

[design/ferp_datapath.sv]
// Datapath holding the run counters, the shift register and the output command register.
module ferp_datapath
  import ferp_pkg::*;
#(
  parameter int COUNT_LIMIT = COUNT_LIMIT_DEF
)
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic [SECTOR_W-1:0]   start_sector,
  input  logic [COUNT_W-1:0]    sector_count,
  input  logic [SHIFT_W-1:0]    shift_value,
  input  logic                  shift_write,
  output logic [SHIFT_W-1:0]    sector_shift,
  input  ctrl_cmd_t             cmd,
  output ctrl_status_t          status,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [OPCODE_W-1:0]   erase_opcode,
  output logic [ADDR_W-1:0]     byte_address,
  output logic [UNIT_W-1:0]     sectors_covered,
  output logic                  last_command
);

  localparam int CNT_W = $clog2(COUNT_LIMIT + 1);

  logic [SECTOR_W-1:0] current_sector;
  logic [CNT_W-1:0]    sectors_remaining;
  logic [CNT_W-1:0]    count_sat;
  logic [CNT_W-1:0]    remaining_next;
  logic [UNIT_W-1:0]   unit;
  logic [OPCODE_W-1:0] opcode;

  always_comb begin
    if (sector_count > COUNT_W'(COUNT_LIMIT)) begin
      count_sat = CNT_W'(COUNT_LIMIT);
    end else begin
      count_sat = CNT_W'(sector_count);
    end
  end

  always_comb begin
    priority if (current_sector[3:0] == 4'd0 && sectors_remaining >= CNT_W'(UNIT64)) begin
      unit = UNIT64;
      opcode = OP_BLOCK64;
    end else if (current_sector[2:0] == 3'd0 && sectors_remaining >= CNT_W'(UNIT32)) begin
      unit = UNIT32;
      opcode = OP_BLOCK32;
    end else begin
      unit = UNIT1;
      opcode = OP_SECTOR;
    end
  end

  assign remaining_next = sectors_remaining - CNT_W'(unit);

  assign status.count_nonzero = (sector_count != '0);
  assign status.slot_free = !out_valid || out_ready;
  assign status.step_last = (remaining_next == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      sector_shift <= SHIFT_RESET;
    end else if (shift_write) begin
      sector_shift <= shift_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_sector <= '0;
      sectors_remaining <= '0;
    end else if (cmd.load) begin
      current_sector <= start_sector;
      sectors_remaining <= count_sat;
    end else if (cmd.step) begin
      current_sector <= current_sector + SECTOR_W'(unit);
      sectors_remaining <= remaining_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      erase_opcode <= opcode;
      byte_address <= ADDR_W'(current_sector) << sector_shift;
      sectors_covered <= unit;
      last_command <= (remaining_next == '0);
    end
  end

`ifndef NO_ASSERTIONS
  a_step_needs_work: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> sectors_remaining != '0)
    else $error("step issued with no sectors remaining");

  a_result_not_dropped: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(byte_address))
    else $error("stalled command lost or changed");

  a_unit_matches_opcode: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (sectors_covered == UNIT64 && erase_opcode == OP_BLOCK64) ||
                  (sectors_covered == UNIT32 && erase_opcode == OP_BLOCK32) ||
                  (sectors_covered == UNIT1 && erase_opcode == OP_SECTOR))
    else $error("erase opcode and sector count disagree");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    cmd.step && status.step_last |=> sectors_remaining == '0)
    else $error("run did not end after its last command");
`endif

endmodule

[design/flash_erase_range_planner_core.sv]
// Top level of the SPI NOR erase range planner: APB register port and stream channels.
//
// Channel     Direction  Signals                       Contents
// s_axis      in         s_tvalid/s_tready/s_tdata     erase request
// m_axis      out        m_tvalid/m_tready/m_tdata     erase command, tlast on final one
// apb         in         psel/penable/pwrite/paddr     sector_shift register
//
// A request is accepted in the idle state, then one command is emitted per cycle
// while m_tready does not stall the output; the command counter and the single
// output register pace the run.
// Reset is synchronous and active high; sector_shift returns to 12.
// A stall on m_tready holds the current command and pauses the run.
module flash_erase_range_planner_core
  import ferp_pkg::*;
#(
  parameter int COUNT_LIMIT = COUNT_LIMIT_DEF
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [11:0] start_sector, [20:12] sector_count, [23:21] zero
  input  logic [23:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] erase_opcode, [31:8] byte_address, [36:32] sectors_covered, [39:37] zero
  output logic [39:0] m_tdata,
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ctrl_cmd_t           cmd;
  ctrl_status_t        status;
  logic [SHIFT_W-1:0]  sector_shift;
  logic                shift_write;
  logic [OPCODE_W-1:0] erase_opcode;
  logic [ADDR_W-1:0]   byte_address;
  logic [UNIT_W-1:0]   sectors_covered;

  assign pready = 1'b1;
  assign shift_write = psel && penable && pwrite && pready &&
                       (paddr[2] == REG_SECTOR_SHIFT[0]);
  assign prdata = (paddr[2] == REG_SECTOR_SHIFT[0]) ? 32'(sector_shift) : 32'd0;

  ferp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ferp_datapath #(
    .COUNT_LIMIT (COUNT_LIMIT)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .start_sector    (s_tdata[11:0]),
    .sector_count    (s_tdata[20:12]),
    .shift_value     (pwdata[SHIFT_W-1:0]),
    .shift_write     (shift_write),
    .sector_shift    (sector_shift),
    .cmd             (cmd),
    .status          (status),
    .out_ready       (m_tready),
    .out_valid       (m_tvalid),
    .erase_opcode    (erase_opcode),
    .byte_address    (byte_address),
    .sectors_covered (sectors_covered),
    .last_command    (m_tlast)
  );

  assign m_tdata = {3'b000, sectors_covered, byte_address, erase_opcode};

endmodule

[tb/flash_erase_range_planner_core_test.sv]
// Self-checking testbench for the erase range planner: predicts each erase command and compares.
module flash_erase_range_planner_core_test
  import ferp_pkg::*;
();

  localparam int HALF_PERIOD = 10;
  localparam int RESET_CYCLES = 12;
  localparam int IDLE_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 4;
  localparam int REPORT_LIMIT = 10;
  localparam int SECTOR_COUNT = 1 << SECTOR_W;
  localparam logic [2:0] ADDR_SECTOR_SHIFT = 3'(4 * REG_SECTOR_SHIFT);
  localparam logic [2:0] ADDR_UNMAPPED = 3'(4 * (REG_SECTOR_SHIFT + 1));

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [ADDR_W-1:0]   addr;
    logic [UNIT_W-1:0]   covered;
    logic                is_last;
  } erase_cmd_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic [SHIFT_W-1:0] shift_setting = SHIFT_RESET;
  erase_cmd_t         expected_cmds[$];
  bit                 no_idling = 1'b0;
  int                 failures = 0;
  int                 requests_sent = 0;
  int                 cmds_checked = 0;
  int                 shifts_used = 0;
  int                 idle_cycles = 0;
  int                 ready_hold = 0;

  flash_erase_range_planner_core u_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic void note_failure(input string msg);
    failures++;
    if (failures <= REPORT_LIMIT) begin
      $display("%s", msg);
    end
  endfunction

  // Largest erase unit that fits at each step, addresses from the current shift.
  function automatic void plan_erase_run(input logic [SECTOR_W-1:0] start,
                                         input logic [COUNT_W-1:0] count);
    logic [SECTOR_W-1:0] sector;
    int unsigned         left;
    int unsigned         unit;
    logic [63:0]         wide;
    erase_cmd_t          cmd;
    sector = start;
    left = 32'(count);
    if (left > COUNT_LIMIT_DEF) begin
      left = COUNT_LIMIT_DEF;
    end
    while (left > 0) begin
      if ((sector % UNIT64) == 0 && left >= UNIT64) begin
        unit = 32'(UNIT64);
        cmd.opcode = OP_BLOCK64;
      end else if ((sector % UNIT32) == 0 && left >= UNIT32) begin
        unit = 32'(UNIT32);
        cmd.opcode = OP_BLOCK32;
      end else begin
        unit = 32'(UNIT1);
        cmd.opcode = OP_SECTOR;
      end
      wide = 64'(sector) << shift_setting;
      cmd.addr = wide[ADDR_W-1:0];
      cmd.covered = UNIT_W'(unit);
      left -= unit;
      cmd.is_last = (left == 0);
      expected_cmds.push_back(cmd);
      sector = SECTOR_W'((int'(sector) + unit) % SECTOR_COUNT);
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idling || r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // Leaves s_tvalid high after acceptance so a back-to-back request follows without an idle gap.
  task automatic send_request(input logic [SECTOR_W-1:0] start,
                              input logic [COUNT_W-1:0] count);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata <= {3'b000, count, start};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    plan_erase_run(start, count);
    requests_sent++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_cmds.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    logic [31:0] want;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    if (wr) begin
      if (addr == ADDR_SECTOR_SHIFT) begin
        shift_setting = data[SHIFT_W-1:0];
      end
    end else if (addr == ADDR_SECTOR_SHIFT) begin
      want = 32'(shift_setting);
      if (prdata !== want) begin
        note_failure($sformatf("sector_shift read: expected %0d, got %0d", want, prdata));
      end
    end
  endtask

  task automatic set_shift(input logic [SHIFT_W-1:0] value);
    wait_drained();
    apb_access(1'b1, ADDR_SECTOR_SHIFT, {27'($urandom_range(0, 2 ** 27 - 1)), value});
    apb_access(1'b0, ADDR_SECTOR_SHIFT, '0);
    shifts_used++;
  endtask

  task automatic random_request();
    logic [SECTOR_W-1:0] start;
    logic [COUNT_W-1:0]  count;
    int                  r;
    r = $urandom_range(0, 99);
    start = SECTOR_W'($urandom_range(0, SECTOR_COUNT - 1));
    if (r < 35) begin
      start[3:0] = '0;
    end else if (r < 55) begin
      start[2:0] = '0;
    end else if (r < 65) begin
      start = SECTOR_W'($urandom_range(SECTOR_COUNT - 32, SECTOR_COUNT - 1));
    end
    r = $urandom_range(0, 99);
    if (r < 70) begin
      count = COUNT_W'($urandom_range(1, 40));
    end else if (r < 90) begin
      count = COUNT_W'($urandom_range(41, 200));
    end else if (r < 97) begin
      count = COUNT_W'($urandom_range(201, COUNT_LIMIT_DEF));
    end else begin
      count = '0;
    end
    send_request(start, count);
  endtask

  task automatic test_reset_value();
    apb_access(1'b0, ADDR_SECTOR_SHIFT, '0);
    send_request(12'd0, 9'd1);
    send_request(12'd0, 9'd16);
  endtask

  task automatic test_directed_ranges();
    send_request(12'd0, 9'd511);
    send_request(12'd1, 9'd511);
    send_request(12'd4095, 9'd511);
    send_request(12'd4095, 9'd1);
    send_request(12'd8, 9'd16);
    send_request(12'd8, 9'd8);
    send_request(12'd4088, 9'd24);
    send_request(12'd15, 9'd17);
    send_request(12'd0, 9'd7);
    send_request(12'hAAA, 9'h155);
    send_request(12'h555, 9'h0AA);
    send_request(12'd100, 9'd0);
    send_request(12'd4080, 9'd16);
  endtask

  task automatic test_shift_extremes();
    set_shift(5'd8);
    send_request(12'd4095, 9'd3);
    set_shift(5'd16);
    send_request(12'd4064, 9'd40);
    set_shift(5'd0);
    send_request(12'd4095, 9'd2);
    set_shift(5'd31);
    send_request(12'd1, 9'd17);
    wait_drained();
    apb_access(1'b1, ADDR_UNMAPPED, 32'h0000_0005);
    apb_access(1'b0, ADDR_SECTOR_SHIFT, '0);
    send_request(12'd3, 9'd5);
  endtask

  task automatic test_random_ranges();
    logic [SHIFT_W-1:0] phase_shift[6];
    phase_shift = '{5'd12, 5'd8, 5'd16, SHIFT_W'($urandom_range(0, 31)), 5'd31, 5'd0};
    foreach (phase_shift[p]) begin
      set_shift(phase_shift[p]);
      no_idling = (p == 1 || p == 4);
      repeat (39) random_request();
    end
    no_idling = 1'b0;
  endtask

  always @(posedge clk) begin
    if (no_idling) begin
      m_tready <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) begin
        m_tready <= 1'b1;
        ready_hold <= $urandom_range(0, 3);
      end else if (r < 95) begin
        m_tready <= 1'b0;
        ready_hold <= $urandom_range(0, 2);
      end else begin
        m_tready <= 1'b0;
        ready_hold <= $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk) begin
    erase_cmd_t got;
    erase_cmd_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[7:0], m_tdata[31:8], m_tdata[36:32], m_tlast};
      if (expected_cmds.size() == 0) begin
        note_failure($sformatf("unexpected command: op %h addr %h covered %0d last %0b",
                               got.opcode, got.addr, got.covered, got.is_last));
      end else begin
        want = expected_cmds.pop_front();
        cmds_checked++;
        if (got.opcode !== want.opcode) begin
          note_failure($sformatf("erase_opcode: expected %h, got %h", want.opcode, got.opcode));
        end
        if (got.addr !== want.addr) begin
          note_failure($sformatf("byte_address: expected %h, got %h", want.addr, got.addr));
        end
        if (got.covered !== want.covered) begin
          note_failure($sformatf("sectors_covered: expected %0d, got %0d",
                                 want.covered, got.covered));
        end
        if (got.is_last !== want.is_last) begin
          note_failure($sformatf("last_command: expected %0b, got %0b",
                                 want.is_last, got.is_last));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("timeout: no request or command moved for %0d cycles", IDLE_LIMIT);
    $display("flash_erase_range_planner_core_test: done, errors");
    $finish;
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_value();
    test_directed_ranges();
    test_shift_extremes();
    test_random_ranges();
    wait_drained();
    repeat (20) @(posedge clk);
    if (expected_cmds.size() != 0) begin
      note_failure($sformatf("%0d expected commands never arrived", expected_cmds.size()));
    end
    $display("Sent %0d erase requests under %0d shift settings; checked %0d commands.",
             requests_sent, shifts_used, cmds_checked);
    $display("Found %0d failures.", failures);
    if (failures == 0) begin
      $display("flash_erase_range_planner_core_test: done, clean");
    end else begin
      $display("flash_erase_range_planner_core_test: done, errors");
    end
    $finish;
  end

endmodule

[filelist.f]
design/ferp_pkg.sv
design/ferp_ctrl.sv
design/ferp_datapath.sv
design/flash_erase_range_planner_core.sv
tb/flash_erase_range_planner_core_test.sv
